[src/lpbf_pkg.sv]
// shared constants and types for the led packet bit framer
package lpbf_pkg;

  // longest payload the framer sends
  localparam int unsigned MaxPayloadBits = 8;

  localparam int unsigned LenW      = 4;
  localparam int unsigned IdleW     = 7;
  localparam int unsigned StopW     = 6;
  localparam int unsigned StopCntW  = StopW + 1;
  localparam int unsigned PayloadW  = 8;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned CfgIndexW = 2;

  localparam int unsigned InFieldW  = 1 + 2 + PayloadW;
  localparam int unsigned InDataW   = ((InFieldW + 7) / 8) * 8;
  localparam int unsigned OutDataW  = 8;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    REG_PAYLOAD_LENGTH = 2'd0,
    REG_IDLE_COUNT     = 2'd1,
    REG_STOP_PAIRS     = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  // tick modes
  typedef enum logic [1:0] {
    MODE_STEADY  = 2'd0,
    MODE_PACKET  = 2'd1,
    MODE_TOGGLE  = 2'd2,
    MODE_STEADY2 = 2'd3
  } tick_mode_t;

  localparam logic [LenW-1:0]     LenReset     = LenW'(MaxPayloadBits);
  localparam logic [IdleW-1:0]    IdleReset    = IdleW'(1);
  localparam logic [StopW-1:0]    StopReset    = StopW'(1);
  localparam logic [StopCntW-1:0] StopCntReset = StopCntW'(2);
  localparam logic [PayloadW-1:0] PayloadReset = PayloadW'(85);

endpackage

[src/led_packet_bit_framer_core.sv]
// top level of the led packet bit framer
//
// each request on the in_ side is one bit-time tick and yields exactly one
// result on the out_ side carrying the led level for that bit time. the block
// takes one request per clock cycle: all framing work is a few counter
// updates done between acceptance and the result register, so the sustained
// rate is one tick per cycle, limited only by the single output register
// (in_tready is low only while a result waits and out_tready is low). the
// result is shown in the cycle after acceptance. in packet mode the
// led line carries idle ones, a zero start bit, the payload msb first over
// payload_length bits, then stop_pairs pairs of 1,0; the payload byte is
// sampled on the start-bit tick. steady and toggle modes drive the led on or
// flip it and put the framer back to idle. a tick with enable low repeats the
// present level and changes nothing. configuration writes saturate into the
// legal ranges and are meant to be done while the stream is quiet.
module led_packet_bit_framer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // tick requests
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lpbf_pkg::InDataW-1:0]    in_tdata,   // enable, mode[1:0], payload_value[7:0]
  // led level results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lpbf_pkg::OutDataW-1:0]   out_tdata,  // led_level
  // register writes
  input  logic                            cfg_we,
  input  logic [lpbf_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [lpbf_pkg::CfgDataW-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_START   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_STOP    = 2'd3
  } phase_t;

  // configuration
  logic [lpbf_pkg::LenW-1:0]      payload_length_r;
  logic [lpbf_pkg::IdleW-1:0]     idle_count_r;
  logic [lpbf_pkg::StopW-1:0]     stop_pairs_r;

  // framer state
  phase_t                         phase_r, phase_nxt;
  logic                           led_now_r, led_now_nxt;
  logic [lpbf_pkg::IdleW-1:0]     idle_rem_r, idle_rem_nxt;
  logic [lpbf_pkg::StopCntW-1:0]  stop_rem_r, stop_rem_nxt;
  logic [lpbf_pkg::LenW-1:0]      bit_idx_r, bit_idx_nxt;
  logic [lpbf_pkg::PayloadW-1:0]  latched_r, latched_nxt;

  // result register
  logic                           out_valid_r;

  // request fields
  logic                           t_enable;
  lpbf_pkg::tick_mode_t           t_mode;
  logic [lpbf_pkg::PayloadW-1:0]  t_payload;
  logic                           accept;

  // scratch for the framing step
  logic [lpbf_pkg::LenW-1:0]      pos;
  logic [lpbf_pkg::LenW-1:0]      idx_inc;
  logic [lpbf_pkg::StopCntW-1:0]  stop_dec;
  logic [lpbf_pkg::LenW-1:0]      len_wr;
  logic [lpbf_pkg::StopW-1:0]     stop_wr;

  assign t_enable  = in_tdata[0];
  assign t_mode    = lpbf_pkg::tick_mode_t'(in_tdata[2:1]);
  assign t_payload = in_tdata[3 +: lpbf_pkg::PayloadW];

  // output register frees up as soon as its content is taken
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lpbf_pkg::OutDataW-1){1'b0}}, led_now_r};

  // saturate register writes into their legal ranges
  always_comb begin
    len_wr = cfg_wdata[lpbf_pkg::LenW-1:0];
    if (len_wr == '0) begin
      len_wr = lpbf_pkg::LenW'(1);
    end else if (len_wr > lpbf_pkg::LenW'(lpbf_pkg::MaxPayloadBits)) begin
      len_wr = lpbf_pkg::LenW'(lpbf_pkg::MaxPayloadBits);
    end
    stop_wr = cfg_wdata[lpbf_pkg::StopW-1:0];
    if (stop_wr == '0) begin
      stop_wr = lpbf_pkg::StopW'(1);
    end
  end

  // one framing step per enabled tick
  always_comb begin
    phase_nxt    = phase_r;
    led_now_nxt  = led_now_r;
    idle_rem_nxt = idle_rem_r;
    stop_rem_nxt = stop_rem_r;
    bit_idx_nxt  = bit_idx_r;
    latched_nxt  = latched_r;
    pos          = payload_length_r - bit_idx_r - lpbf_pkg::LenW'(1);
    idx_inc      = bit_idx_r + lpbf_pkg::LenW'(1);
    stop_dec     = (stop_rem_r != '0) ? stop_rem_r - lpbf_pkg::StopCntW'(1) : '0;
    if (t_enable) begin
      if (t_mode == lpbf_pkg::MODE_PACKET) begin
        unique case (phase_r)
          PH_IDLE: begin
            led_now_nxt = 1'b1;
            // zero idle count behaves as a single idle bit
            if (idle_rem_r <= lpbf_pkg::IdleW'(1)) begin
              idle_rem_nxt = '0;
              phase_nxt    = PH_START;
            end else begin
              idle_rem_nxt = idle_rem_r - lpbf_pkg::IdleW'(1);
            end
          end
          PH_START: begin
            led_now_nxt = 1'b0;
            latched_nxt = t_payload;
            phase_nxt   = PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            // a length shrunk below the current index sends a zero and ends
            if (bit_idx_r < payload_length_r && pos < lpbf_pkg::LenW'(lpbf_pkg::PayloadW)) begin
              led_now_nxt = latched_r[pos[$clog2(lpbf_pkg::PayloadW)-1:0]];
            end else begin
              led_now_nxt = 1'b0;
            end
            bit_idx_nxt = idx_inc;
            if (idx_inc == '0 || idx_inc >= payload_length_r) begin
              bit_idx_nxt  = '0;
              phase_nxt    = PH_STOP;
              stop_rem_nxt = {stop_pairs_r, 1'b0};
            end
          end
          PH_STOP: begin
            // odd count sends 0, even count sends 1
            led_now_nxt  = ~stop_rem_r[0];
            stop_rem_nxt = stop_dec;
            if (stop_dec == '0) begin
              phase_nxt    = PH_IDLE;
              idle_rem_nxt = idle_count_r;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end else begin
        led_now_nxt  = (t_mode == lpbf_pkg::MODE_TOGGLE) ? ~led_now_r : 1'b1;
        phase_nxt    = PH_IDLE;
        idle_rem_nxt = idle_count_r;
        bit_idx_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_length_r <= lpbf_pkg::LenReset;
      idle_count_r     <= lpbf_pkg::IdleReset;
      stop_pairs_r     <= lpbf_pkg::StopReset;
      phase_r          <= PH_IDLE;
      led_now_r        <= 1'b1;
      idle_rem_r       <= lpbf_pkg::IdleW'(1);
      stop_rem_r       <= lpbf_pkg::StopCntReset;
      bit_idx_r        <= '0;
      latched_r        <= lpbf_pkg::PayloadReset;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (lpbf_pkg::cfg_reg_t'(cfg_index))
          lpbf_pkg::REG_PAYLOAD_LENGTH: payload_length_r <= len_wr;
          lpbf_pkg::REG_IDLE_COUNT:     idle_count_r     <= cfg_wdata[lpbf_pkg::IdleW-1:0];
          lpbf_pkg::REG_STOP_PAIRS:     stop_pairs_r     <= stop_wr;
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase_r    <= phase_nxt;
        led_now_r  <= led_now_nxt;
        idle_rem_r <= idle_rem_nxt;
        stop_rem_r <= stop_rem_nxt;
        bit_idx_r  <= bit_idx_nxt;
        latched_r  <= latched_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // saturation keeps the length inside 1..max
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    payload_length_r != '0 &&
    payload_length_r <= lpbf_pkg::LenW'(lpbf_pkg::MaxPayloadBits))
    else $error("payload length out of range");

  // stop phase never sits on an empty counter
  a_stop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOP |-> stop_rem_r != '0)
    else $error("stop phase with zero count");

  // start bit is only reached once idle bits are used up
  a_start_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_START |-> idle_rem_r == '0)
    else $error("start phase with idle bits left");

  // a disabled tick repeats the present level
  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !t_enable |=> out_tvalid && out_tdata[0] == $past(led_now_r))
    else $error("disabled tick changed the level");

  // a taken request always produces a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request without result");

endmodule

[dv/led_packet_bit_framer_core_tb.sv]
// self-checking testbench for the led packet bit framer core
`timescale 1ns / 100ps

module led_packet_bit_framer_core_tb;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomTicks   = 950;

  // kinds of rows in the directed script
  typedef enum bit {
    ROW_TICK = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  // one directed step: a tick request or a register write (value in val)
  typedef struct packed {
    row_kind_t            kind;
    logic                 en;
    lpbf_pkg::tick_mode_t mode;
    logic [7:0]           val;
    lpbf_pkg::cfg_reg_t   idx;
    logic                 pinned;   // level below is known by inspection
    logic                 lvl;
  } step_row_t;

  // phases of the framer as the predictor tracks them
  typedef enum logic [1:0] {
    FR_IDLE    = 2'd0,
    FR_START   = 2'd1,
    FR_PAYLOAD = 2'd2,
    FR_STOP    = 2'd3
  } frame_phase_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [lpbf_pkg::InDataW-1:0]   in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lpbf_pkg::OutDataW-1:0]  out_tdata;
  logic                           cfg_we = 1'b0;
  lpbf_pkg::cfg_reg_t             cfg_index = lpbf_pkg::REG_PAYLOAD_LENGTH;
  logic [lpbf_pkg::CfgDataW-1:0]  cfg_wdata = '0;

  // predictor copy of the registers
  logic [lpbf_pkg::LenW-1:0]      len_cfg;
  logic [lpbf_pkg::IdleW-1:0]     idle_cfg;
  logic [lpbf_pkg::StopW-1:0]     stop_cfg;

  // predictor copy of the framer state
  frame_phase_t                   frame_phase;
  logic                           led_state;
  logic [7:0]                     idle_run;
  logic [lpbf_pkg::StopCntW-1:0]  stop_left;
  logic [3:0]                     bit_pos;
  logic [lpbf_pkg::PayloadW-1:0]  held_byte;

  // expected led levels, oldest first, and per-request pinned levels
  logic                 led_q [$];
  logic [1:0]           pin_q [$];

  int unsigned          mismatches = 0;
  int unsigned          quiet_cycles = 0;

  // sender and receiver idling knobs
  int unsigned          gap_max = 0;
  int unsigned          burst_left = 0;
  int unsigned          stall_style = 0;
  logic [15:0]          stall_pat = 16'hffff;
  logic [3:0]           rcv_slot = '0;

  // directed script: register extremes, zero idle, every mode, disabled
  // ticks, length shrunk in the middle of a payload, unknown register
  step_row_t script_rows [34] = '{
    '{ROW_CFG,  1'b0, lpbf_pkg::MODE_STEADY,  8'd0,  lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    '{ROW_CFG,  1'b0, lpbf_pkg::MODE_STEADY,  8'd0,  lpbf_pkg::REG_STOP_PAIRS,     1'b0, 1'b0},
    '{ROW_CFG,  1'b0, lpbf_pkg::MODE_STEADY,  8'd0,  lpbf_pkg::REG_IDLE_COUNT,     1'b0, 1'b0},
    // disabled tick shows the reset level
    '{ROW_TICK, 1'b0, lpbf_pkg::MODE_PACKET,  8'hff, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b1},
    // one idle bit, start bit, single payload bit, one stop pair
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b1},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'hff, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b1},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b1},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b0},
    // zero idle count acts as one idle bit
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h80, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h7f, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    // writes land while the stop pair is still in flight
    '{ROW_CFG,  1'b0, lpbf_pkg::MODE_STEADY,  8'd15, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    '{ROW_CFG,  1'b0, lpbf_pkg::MODE_STEADY,  8'd63, lpbf_pkg::REG_STOP_PAIRS,     1'b0, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    '{ROW_CFG,  1'b0, lpbf_pkg::MODE_STEADY,  8'd2,  lpbf_pkg::REG_IDLE_COUNT,     1'b0, 1'b0},
    // steady, toggle, disabled toggle, alternate steady code
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_STEADY,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b1},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_TOGGLE,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b0},
    '{ROW_TICK, 1'b0, lpbf_pkg::MODE_TOGGLE,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_TOGGLE,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b1},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_STEADY2, 8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b1},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_TOGGLE,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b0},
    // full length packet, cut short by a length write mid payload
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'haa, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h55, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h55, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    '{ROW_CFG,  1'b0, lpbf_pkg::MODE_STEADY,  8'd1,  lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b1, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    // toggle in the middle of a long stop run
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_TOGGLE,  8'h00, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0},
    // write to the unused index must change nothing
    '{ROW_CFG,  1'b0, lpbf_pkg::MODE_STEADY,  8'h7f, lpbf_pkg::REG_UNUSED,         1'b0, 1'b0},
    '{ROW_TICK, 1'b1, lpbf_pkg::MODE_PACKET,  8'hff, lpbf_pkg::REG_PAYLOAD_LENGTH, 1'b0, 1'b0}
  };

  led_packet_bit_framer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // prints one line per mismatch and counts it
  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // register write as the framer sees it, with its saturation
  function automatic void apply_reg(input lpbf_pkg::cfg_reg_t idx,
                                    input logic [lpbf_pkg::CfgDataW-1:0] data);
    case (idx)
      lpbf_pkg::REG_PAYLOAD_LENGTH: begin
        if (data[3:0] == 4'd0) len_cfg = 4'd1;
        else if (data[3:0] > lpbf_pkg::LenW'(lpbf_pkg::MaxPayloadBits))
          len_cfg = lpbf_pkg::LenW'(lpbf_pkg::MaxPayloadBits);
        else len_cfg = data[3:0];
      end
      lpbf_pkg::REG_IDLE_COUNT: idle_cfg = data[lpbf_pkg::IdleW-1:0];
      lpbf_pkg::REG_STOP_PAIRS:
        stop_cfg = (data[lpbf_pkg::StopW-1:0] == '0) ? lpbf_pkg::StopW'(1)
                                                     : data[lpbf_pkg::StopW-1:0];
      default: ;
    endcase
  endfunction

  // advances the predicted framer by one tick and returns the led level
  function automatic logic led_for_tick(input logic en, input lpbf_pkg::tick_mode_t mode,
                                        input logic [7:0] val);
    int pos;
    if (en) begin
      if (mode == lpbf_pkg::MODE_PACKET) begin
        case (frame_phase)
          FR_IDLE: begin
            led_state = 1'b1;
            if (idle_run <= 8'd1) begin
              idle_run = '0;
              frame_phase = FR_START;
            end else begin
              idle_run = idle_run - 8'd1;
            end
          end
          FR_START: begin
            led_state = 1'b0;
            held_byte = val;
            frame_phase = FR_PAYLOAD;
          end
          FR_PAYLOAD: begin
            if (bit_pos < len_cfg) begin
              pos = int'(len_cfg) - int'(bit_pos) - 1;
              led_state = (pos < 8) ? held_byte[pos] : 1'b0;
            end else begin
              // length shrunk under a running payload
              led_state = 1'b0;
            end
            bit_pos = bit_pos + 4'd1;
            if (bit_pos == 4'd0 || bit_pos >= len_cfg) begin
              bit_pos = '0;
              frame_phase = FR_STOP;
              stop_left = {stop_cfg, 1'b0};
            end
          end
          default: begin
            led_state = ~stop_left[0];
            if (stop_left != '0) stop_left = stop_left - 1'b1;
            if (stop_left == '0) begin
              frame_phase = FR_IDLE;
              idle_run = 8'(idle_cfg);
            end
          end
        endcase
      end else begin
        led_state = (mode == lpbf_pkg::MODE_TOGGLE) ? ~led_state : 1'b1;
        frame_phase = FR_IDLE;
        idle_run = 8'(idle_cfg);
        bit_pos = '0;
      end
    end
    return led_state;
  endfunction

  // predictor and scoreboard, all on sampled pre-edge values
  always @(posedge clk) begin
    logic [1:0] pin;
    logic       lvl;
    logic       want;
    if (!rst_n) begin
      len_cfg     = lpbf_pkg::LenReset;
      idle_cfg    = lpbf_pkg::IdleReset;
      stop_cfg    = lpbf_pkg::StopReset;
      frame_phase = FR_IDLE;
      led_state   = 1'b1;
      idle_run    = 8'd1;
      stop_left   = lpbf_pkg::StopCntReset;
      bit_pos     = '0;
      held_byte   = lpbf_pkg::PayloadReset;
    end else begin
      // results first so a result never matches a request of the same edge
      if (out_tvalid && out_tready) begin
        if (led_q.size() == 0) begin
          report_mismatch($sformatf("led result %0b with no request waiting", out_tdata[0]));
        end else begin
          want = led_q.pop_front();
          if (out_tdata[0] !== want)
            report_mismatch($sformatf("led_level got %0b want %0b", out_tdata[0], want));
        end
      end
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) begin
        pin = 2'b00;
        if (pin_q.size() != 0) pin = pin_q.pop_front();
        lvl = led_for_tick(in_tdata[0], lpbf_pkg::tick_mode_t'(in_tdata[2:1]),
                           in_tdata[10:3]);
        led_q.push_back(pin[1] ? pin[0] : lvl);
      end
    end
  end

  // receiver: always ready, random stalls, or a repeating stall pattern
  always @(posedge clk) begin
    rcv_slot <= rcv_slot + 4'd1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      case (stall_style)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 99) < 70);
        default: out_tready <= stall_pat[rcv_slot];
      endcase
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL led_packet_bit_framer_core");
      $finish;
    end
  end

  // offers one tick request and waits for it to be taken, then maybe a gap
  task automatic push_tick(input logic en, input lpbf_pkg::tick_mode_t mode,
                           input logic [7:0] val, input logic pinned, input logic lvl);
    pin_q.push_back({pinned, lvl});
    in_tdata  <= lpbf_pkg::InDataW'({val, mode, en});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left != 0) burst_left--;
    if (burst_left == 0 && gap_max != 0) begin
      burst_left = $urandom_range(1, 24);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
    end
  endtask

  task automatic hold_sender();
    in_tvalid <= 1'b0;
  endtask

  // waits until every predicted level has come back
  task automatic wait_drained();
    @(posedge clk);
    while (led_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input lpbf_pkg::cfg_reg_t idx,
                           input logic [lpbf_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned          sent;
    int unsigned          phase_len;
    int unsigned          noise_pct;
    int unsigned          roll;
    logic                 en;
    lpbf_pkg::tick_mode_t mode;
    logic [7:0]           val;
    logic [6:0]           len_raw;
    logic [6:0]           idle_raw;
    logic [6:0]           stop_raw;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with light idling on both sides
    gap_max = 2;
    stall_style = 1;
    foreach (script_rows[r]) begin
      if (script_rows[r].kind == ROW_CFG) begin
        hold_sender();
        wait_drained();
        write_reg(script_rows[r].idx, script_rows[r].val[lpbf_pkg::CfgDataW-1:0]);
      end else begin
        push_tick(script_rows[r].en, script_rows[r].mode, script_rows[r].val,
                  script_rows[r].pinned, script_rows[r].lvl);
      end
    end

    // random part in phases; each phase starts with the stream drained
    sent = 0;
    for (int p = 0; sent < RandomTicks; p++) begin
      hold_sender();
      wait_drained();

      case (p % 5)
        1: begin
          len_raw = 7'd15;
          idle_raw = 7'd127;
          stop_raw = 7'd63;
        end
        2: begin
          len_raw = 7'd0;
          idle_raw = 7'd0;
          stop_raw = 7'd0;
        end
        default: begin
          len_raw = 7'($urandom_range(0, 127));
          // mostly short idle and stop runs so packets finish often
          idle_raw = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(0, 6));
          stop_raw = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(0, 3));
        end
      endcase
      write_reg(lpbf_pkg::REG_PAYLOAD_LENGTH, len_raw);
      write_reg(lpbf_pkg::REG_IDLE_COUNT, idle_raw);
      write_reg(lpbf_pkg::REG_STOP_PAIRS, stop_raw);
      if (p % 3 == 0) write_reg(lpbf_pkg::REG_UNUSED, 7'($urandom_range(0, 127)));

      // first phase runs with no idling at all
      gap_max     = (p == 0) ? 0 : $urandom_range(0, 2) * 4;
      stall_style = (p == 0) ? 0 : $urandom_range(0, 2);
      stall_pat   = 16'($urandom_range(0, 65535)) | 16'h0001;
      noise_pct   = (p % 4 == 0) ? 0 : 15;
      phase_len   = $urandom_range(40, 120);

      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        val  = 8'($urandom_range(0, 255));
        if (roll < noise_pct / 2) begin
          en   = 1'b0;
          mode = lpbf_pkg::tick_mode_t'(2'($urandom_range(0, 3)));
        end else if (roll < noise_pct) begin
          // mode change that drops the framer back to idle
          en   = 1'b1;
          mode = lpbf_pkg::tick_mode_t'(2'($urandom_range(0, 3)));
          if (mode == lpbf_pkg::MODE_PACKET) mode = lpbf_pkg::MODE_TOGGLE;
        end else begin
          en   = 1'b1;
          mode = lpbf_pkg::MODE_PACKET;
        end
        push_tick(en, mode, val, 1'b0, 1'b0);
        if (en) sent++;
      end
    end

    hold_sender();
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("PASS led_packet_bit_framer_core");
    else
      $display("FAIL led_packet_bit_framer_core");
    $finish;
  end

endmodule

[files.f]
src/lpbf_pkg.sv
src/led_packet_bit_framer_core.sv
dv/led_packet_bit_framer_core_tb.sv
